// File: rtl/bda_pkg.sv
// Shared types and constants for the button debouncer with autorepeat.
package bda_pkg;

    localparam int unsigned NUM_BUTTONS = 5;
    localparam int unsigned NUM_KEYS    = NUM_BUTTONS + 4;
    localparam int unsigned CODE_KEYS   = 8;

    localparam int unsigned KEY_RIGHT = NUM_BUTTONS;
    localparam int unsigned KEY_LEFT  = NUM_BUTTONS + 1;
    localparam int unsigned KEY_UP    = NUM_BUTTONS + 2;
    localparam int unsigned KEY_DOWN  = NUM_BUTTONS + 3;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESSED_LEVEL   = 3'd0,
        REG_UPPER_PRESS     = 3'd1,
        REG_UPPER_RELEASE   = 3'd2,
        REG_LOWER_PRESS     = 3'd3,
        REG_LOWER_RELEASE   = 3'd4,
        REG_REPEAT_INITIAL  = 3'd5,
        REG_REPEAT_INTERVAL = 3'd6
    } t_cfg_reg;

    localparam logic [7:0]  RST_PRESSED_LEVEL   = 8'd10;
    localparam logic [11:0] RST_UPPER_PRESS     = 12'd3000;
    localparam logic [11:0] RST_UPPER_RELEASE   = 12'd2800;
    localparam logic [11:0] RST_LOWER_PRESS     = 12'd1000;
    localparam logic [11:0] RST_LOWER_RELEASE   = 12'd1200;
    localparam logic [15:0] RST_REPEAT_INITIAL  = 16'd100;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd10;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic [11:0]            joystick_x;
        logic [11:0]            joystick_y;
    } t_in;

    typedef struct packed {
        logic [NUM_KEYS-1:0] debounced;
        logic [NUM_KEYS-1:0] presses;
        logic [3:0]          press_code;
    } t_out;

    typedef struct packed {
        logic [15:0] initial_ticks;
        logic [15:0] interval_ticks;
    } t_repeat_cfg;

endpackage

// File: rtl/bda_repeat.sv
// Per-key hold counter and autorepeat phase counter.
module bda_repeat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_held,
    input  bda_pkg::t_repeat_cfg i_cfg,
    output logic                 o_repeat
);
    import bda_pkg::*;

    logic [15:0] r_hold;
    logic [15:0] r_phase;
    logic [15:0] n_hold;
    logic [15:0] n_phase;

    always_comb begin
        logic [16:0] phase_inc;
        phase_inc = {1'b0, r_phase} + 17'd1;
        n_hold    = 16'd0;
        n_phase   = 16'd0;
        o_repeat  = 1'b0;
        if (i_held) begin
            n_hold = (r_hold == 16'hFFFF) ? r_hold : r_hold + 16'd1;
            if (n_hold < i_cfg.initial_ticks) begin
                n_phase = 16'd0;
            end else if (r_hold < i_cfg.initial_ticks) begin
                // crossing tick: first repeat
                n_phase  = 16'd0;
                o_repeat = 1'b1;
            end else if (phase_inc >= {1'b0, i_cfg.interval_ticks}) begin
                n_phase  = 16'd0;
                o_repeat = 1'b1;
            end else begin
                n_phase = phase_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_phase <= '0;
        end else if (i_adv) begin
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

endmodule

// File: rtl/button_debounce_autorepeat.sv
// Top level: button debouncer, joystick hysteresis and autorepeat.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one scan tick per
//   transaction: raw button bits and two joystick samples.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives one result per
//   tick: debounced vector, press vector and highest-press code.
//   Two register stages: the input register, then the per-key update logic
//   feeding the result register. A tick moves on into the result register
//   only when that register is empty or its result is being taken.
//   Throughput is one tick per cycle unless stalled; per-key work is parallel.
//   When the receiver stalls, the result register holds and the input register
//   fills; o_in_ready drops only when both are occupied and the result is not
//   being taken in that cycle.
//   Reset (synchronous, active low) clears integrators, debounced bits, hold
//   and phase counters, empties both registers and loads the default
//   thresholds. Configuration is written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_wdata while no tick is in flight; unknown indexes are ignored.
module button_debounce_autorepeat #(
    parameter int unsigned STEP_UP   = 1,
    parameter int unsigned STEP_DOWN = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bda_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bda_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bda_pkg::t_out                    o_out_data
);
    import bda_pkg::*;

    // configuration
    logic [7:0]  r_pressed_level;
    logic [11:0] r_upper_press;
    logic [11:0] r_upper_release;
    logic [11:0] r_lower_press;
    logic [11:0] r_lower_release;
    t_repeat_cfg r_rep_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level          <= RST_PRESSED_LEVEL;
            r_upper_press            <= RST_UPPER_PRESS;
            r_upper_release          <= RST_UPPER_RELEASE;
            r_lower_press            <= RST_LOWER_PRESS;
            r_lower_release          <= RST_LOWER_RELEASE;
            r_rep_cfg.initial_ticks  <= RST_REPEAT_INITIAL;
            r_rep_cfg.interval_ticks <= RST_REPEAT_INTERVAL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PRESSED_LEVEL:   r_pressed_level          <= i_cfg_wdata[7:0];
                REG_UPPER_PRESS:     r_upper_press            <= i_cfg_wdata[11:0];
                REG_UPPER_RELEASE:   r_upper_release          <= i_cfg_wdata[11:0];
                REG_LOWER_PRESS:     r_lower_press            <= i_cfg_wdata[11:0];
                REG_LOWER_RELEASE:   r_lower_release          <= i_cfg_wdata[11:0];
                REG_REPEAT_INITIAL:  r_rep_cfg.initial_ticks  <= i_cfg_wdata;
                REG_REPEAT_INTERVAL: r_rep_cfg.interval_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid;
    t_in  r_s1;
    logic r_out_valid;
    t_out r_out;
    logic s1_adv;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in_data;
        end
    end

    // debounce state
    logic [7:0]          r_integ [NUM_BUTTONS];
    logic [7:0]          n_integ [NUM_BUTTONS];
    logic [NUM_KEYS-1:0] r_deb;
    logic [NUM_KEYS-1:0] n_deb;

    always_comb begin
        logic [8:0] sum;
        n_deb = r_deb;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            sum = {1'b0, r_integ[b]} + 9'(STEP_UP);
            if (r_s1.raw_buttons[b]) begin
                if (sum >= {1'b0, r_pressed_level}) begin
                    n_integ[b] = r_pressed_level;
                    n_deb[b]   = 1'b1;
                end else begin
                    n_integ[b] = sum[7:0];
                end
            end else if ({1'b0, r_integ[b]} <= 9'(STEP_DOWN)) begin
                n_integ[b] = 8'd0;
                n_deb[b]   = 1'b0;
            end else begin
                n_integ[b] = r_integ[b] - 8'(STEP_DOWN);
            end
        end
        // press test then release test: release wins
        if (r_s1.joystick_x > r_upper_press)   n_deb[KEY_RIGHT] = 1'b1;
        if (r_s1.joystick_x < r_upper_release) n_deb[KEY_RIGHT] = 1'b0;
        if (r_s1.joystick_x < r_lower_press)   n_deb[KEY_LEFT]  = 1'b1;
        if (r_s1.joystick_x > r_lower_release) n_deb[KEY_LEFT]  = 1'b0;
        if (r_s1.joystick_y > r_upper_press)   n_deb[KEY_UP]    = 1'b1;
        if (r_s1.joystick_y < r_upper_release) n_deb[KEY_UP]    = 1'b0;
        if (r_s1.joystick_y < r_lower_press)   n_deb[KEY_DOWN]  = 1'b1;
        if (r_s1.joystick_y > r_lower_release) n_deb[KEY_DOWN]  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_integ[b] <= '0;
            end
        end else if (s1_adv) begin
            r_deb   <= n_deb;
            r_integ <= n_integ;
        end
    end

    // autorepeat per key
    logic [NUM_KEYS-1:0] rep;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        bda_repeat u_repeat (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (s1_adv),
            .i_held   (n_deb[k]),
            .i_cfg    (r_rep_cfg),
            .o_repeat (rep[k])
        );
    end

    // result
    t_out n_out;

    always_comb begin
        n_out.debounced  = n_deb;
        n_out.presses    = (~r_deb & n_deb) | rep;
        n_out.press_code = 4'd0;
        for (int k = 0; k < CODE_KEYS; k++) begin
            if (n_out.presses[k]) begin
                n_out.press_code = 4'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_code_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.press_code != 4'd0) == (|o_out_data.presses[CODE_KEYS-1:0])))
        else $error("press_code disagrees with presses");

    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.presses & ~o_out_data.debounced) == '0))
        else $error("press reported on a key that is not held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule
